// File: rtl/qdd_pkg.sv
// Shared types, constants and the quadrature transition table for the
// detent decoder. No dependencies.
`default_nettype none

package qdd_pkg;

  localparam int unsigned EncoderCountDefault = 4;

  localparam logic [1:0]  PhasesReset   = 2'b11;
  localparam logic [3:0]  TicksReset    = 4'd4;
  localparam logic [15:0] StepSizeReset = 16'd3200;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_CW   = 2'd1,
    EV_CCW  = 2'd2
  } step_event_e;

  typedef enum logic [1:0] {
    REG_MODE_MASK = 2'd0,
    REG_TICKS     = 2'd1,
    REG_STEP_SIZE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_PRIME  = 1'b1
  } command_e;

  typedef struct packed {
    logic [1:0]         phases;
    logic signed [4:0]  acc;
    logic [31:0]        pos;
  } entry_t;

  localparam entry_t EntryReset = '{phases: PhasesReset, acc: 5'sd0, pos: 32'd0};

  // Index is {previous A, previous B, current A, current B}.
  function automatic logic signed [1:0] quad_move(input logic [3:0] idx);
    logic signed [1:0] mv;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: mv = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: mv = 2'sd1;
      default: mv = 2'sd0;
    endcase
    return mv;
  endfunction

endpackage

`default_nettype wire

// File: rtl/quadrature_detent_decoder_core.sv
// An accepted input beat is registered in s1, then in the output registers.
// Throughput: one beat per cycle while the output is not stalled, set by
// the single state memory whose read-modify-write is closed by a one-entry write bypass.
// Reset clears configuration to defaults and marks every channel entry as
// unwritten, so it reads as idle phases with zero accumulator and position.
// Depends on qdd_pkg.
`default_nettype none

module quadrature_detent_decoder_core #(
  parameter int unsigned ENCODER_COUNT = qdd_pkg::EncoderCountDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [1:0]  encoder_index_i,
  input  wire logic        phase_a_i,
  input  wire logic        phase_b_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       channel_o,
  output logic [1:0]       step_event_o,
  output logic signed [16:0] step_delta_o,
  output logic signed [31:0] detent_position_o
);

  localparam int unsigned IdxW = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;

  logic [3:0]  mode_mask_q;
  logic [3:0]  ticks_q;
  logic [15:0] step_size_q;

  qdd_pkg::entry_t mem_q [ENCODER_COUNT];
  qdd_pkg::entry_t mem_rdata_q;
  logic [ENCODER_COUNT-1:0] ent_valid_q;

  logic            s1_valid_q;
  logic            s1_cmd_q;
  logic [1:0]      s1_ch_q;
  logic [1:0]      s1_cur_q;
  logic            s1_in_range_q;

  logic            byp_valid_q;
  logic [IdxW-1:0] byp_addr_q;
  qdd_pkg::entry_t byp_data_q;

  logic            out_valid_q;
  logic [1:0]      channel_q;
  qdd_pkg::step_event_e event_q;
  logic [16:0]     delta_q;
  logic [31:0]     pos_q;

  logic            advance;
  logic            in_accept;
  logic            in_in_range;
  logic [IdxW-1:0] in_addr;
  logic [IdxW-1:0] s1_addr;
  qdd_pkg::entry_t ent_cur;
  qdd_pkg::entry_t ent_new;
  logic signed [1:0] move;
  logic signed [5:0] sum;
  logic signed [5:0] tick;
  logic [15:0]     mag;
  logic            mem_we;
  qdd_pkg::step_event_e event_d;
  logic [16:0]     delta_d;

  assign advance     = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !advance;
  assign in_accept   = in_valid_i && advance;
  assign in_in_range = 32'(encoder_index_i) < ENCODER_COUNT;
  assign in_addr     = IdxW'(encoder_index_i);
  assign s1_addr     = IdxW'(s1_ch_q);
  assign mem_we      = s1_valid_q && advance && s1_in_range_q;

  always_comb begin
    if (!s1_in_range_q) begin
      ent_cur = qdd_pkg::EntryReset;
    end else if (byp_valid_q && byp_addr_q == s1_addr) begin
      ent_cur = byp_data_q;
    end else if (ent_valid_q[s1_addr]) begin
      ent_cur = mem_rdata_q;
    end else begin
      ent_cur = qdd_pkg::EntryReset;
    end
  end

  always_comb begin
    move    = qdd_pkg::quad_move({ent_cur.phases, s1_cur_q});
    sum     = {ent_cur.acc[4], ent_cur.acc} + {{4{move[1]}}, move};
    tick    = $signed({2'b00, ticks_q});
    mag     = mode_mask_q[s1_ch_q] ? step_size_q : 16'd1;
    ent_new = ent_cur;
    event_d = qdd_pkg::EV_NONE;
    delta_d = 17'd0;
    ent_new.phases = s1_cur_q;
    if (s1_cmd_q == qdd_pkg::CMD_PRIME) begin
      ent_new.acc = 5'sd0;
      ent_new.pos = 32'd0;
    end else if (move != 2'sd0) begin
      priority if (sum >= tick) begin
        ent_new.acc = 5'sd0;
        ent_new.pos = ent_cur.pos + 32'd1;
        event_d     = qdd_pkg::EV_CW;
        delta_d     = {1'b0, mag};
      end else if (sum <= -tick) begin
        ent_new.acc = 5'sd0;
        ent_new.pos = ent_cur.pos - 32'd1;
        event_d     = qdd_pkg::EV_CCW;
        delta_d     = 17'd0 - {1'b0, mag};
      end else begin
        ent_new.acc = sum[4:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_mask_q <= 4'd0;
      ticks_q     <= qdd_pkg::TicksReset;
      step_size_q <= qdd_pkg::StepSizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        qdd_pkg::REG_MODE_MASK: mode_mask_q <= cfg_wdata_i[3:0];
        qdd_pkg::REG_TICKS:     ticks_q     <= cfg_wdata_i[3:0];
        qdd_pkg::REG_STEP_SIZE: step_size_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[s1_addr] <= ent_new;
    end
    if (in_accept && in_in_range) begin
      mem_rdata_q <= mem_q[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      byp_valid_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        ent_valid_q[s1_addr] <= 1'b1;
        byp_valid_q          <= 1'b1;
      end
      if (advance) begin
        s1_valid_q  <= in_valid_i;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      byp_addr_q <= s1_addr;
      byp_data_q <= ent_new;
    end
    if (in_accept) begin
      s1_cmd_q      <= command_i;
      s1_ch_q       <= encoder_index_i;
      s1_cur_q      <= {phase_a_i, phase_b_i};
      s1_in_range_q <= in_in_range;
    end
    if (advance && s1_valid_q) begin
      channel_q <= s1_ch_q;
      event_q   <= s1_in_range_q ? event_d : qdd_pkg::EV_NONE;
      delta_q   <= s1_in_range_q ? delta_d : 17'd0;
      pos_q     <= s1_in_range_q ? ent_new.pos : 32'd0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign channel_o         = channel_q;
  assign step_event_o      = event_q;
  assign step_delta_o      = $signed(delta_q);
  assign detent_position_o = $signed(pos_q);

endmodule

`default_nettype wire

// File: rtl/qdd_checker.sv
// Port-level checks for the detent decoder core, bound to its top level.
// Depends on qdd_pkg and quadrature_detent_decoder_core.
`default_nettype none

module qdd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  encoder_index_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  channel_o,
  input wire logic [1:0]  step_event_o,
  input wire logic signed [16:0] step_delta_o,
  input wire logic signed [31:0] detent_position_o
);

  // A result that waits is held unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(channel_o) &&
      $stable(step_event_o) && $stable(step_delta_o) && $stable(detent_position_o))
    else $error("stalled result beat changed");

  // The input side stalls only while a result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A beat that enters and then meets no stall emerges as a result beat on its own channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !in_stall_o |=>
      out_valid_o && channel_o == $past(encoder_index_i, 2))
    else $error("result beat missing or on wrong channel");

  // No detent means no step amount.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_event_o == qdd_pkg::EV_NONE |-> step_delta_o == 17'sd0)
    else $error("step amount without detent");

  // A clockwise step is never negative, and the event code stays in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (step_event_o != qdd_pkg::EV_CW || !step_delta_o[16]) &&
      (step_event_o == qdd_pkg::EV_NONE || step_event_o == qdd_pkg::EV_CW ||
       step_event_o == qdd_pkg::EV_CCW))
    else $error("bad step event or sign");

endmodule

bind quadrature_detent_decoder_core qdd_checker u_qdd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .encoder_index_i   (encoder_index_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .channel_o         (channel_o),
  .step_event_o      (step_event_o),
  .step_delta_o      (step_delta_o),
  .detent_position_o (detent_position_o)
);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for quadrature_detent_decoder_core: a directed table, then random
// encoder rotation with noise, every result beat checked against a local decoder model.
// Depends on qdd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned EncoderCount = qdd_pkg::EncoderCountDefault;
  localparam int          CycleLimit   = 400000;
  localparam int          SettleCycles = 6;
  localparam int          PhaseCount   = 8;
  localparam int          PhaseBeats   = 200;
  localparam int          MaxIdle      = 5;
  localparam int          MaxReports   = 10;
  localparam logic [1:0]  RegUnused    = 2'd3;

  localparam int MoveTable [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  localparam logic [1:0] CwNext  [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
  localparam logic [1:0] CcwNext [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
  localparam logic [3:0] TicksPlan [6] = '{4'd1, 4'd8, 4'd4, 4'd0, 4'd15, 4'd2};
  localparam logic [15:0] SizePlan [6] = '{16'd1, 16'hFFFF, 16'd3200, 16'd0, 16'd7, 16'd500};

  typedef struct packed {
    logic [1:0]           chan;
    qdd_pkg::step_event_e step;
    logic signed [16:0]   delta;
    logic signed [31:0]   pos;
  } detent_result_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    qdd_pkg::command_e cmd;
    logic [1:0]        ch;
    logic [1:0]        ph;
    logic [1:0]        reg_idx;
    logic [15:0]       value;
    bit                typed;
    detent_result_t    want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        command = 1'b0;
  logic [1:0]  encoder_index = '0;
  logic        phase_a = 1'b0;
  logic        phase_b = 1'b0;
  logic        out_stall = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire [1:0]   channel;
  wire [1:0]   step_event;
  wire signed [16:0] step_delta;
  wire signed [31:0] detent_position;

  quadrature_detent_decoder_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .command_i         (command),
    .encoder_index_i   (encoder_index),
    .phase_a_i         (phase_a),
    .phase_b_i         (phase_b),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .channel_o         (channel),
    .step_event_o      (step_event),
    .step_delta_o      (step_delta),
    .detent_position_o (detent_position)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [3:0]  mode_mask  = 4'd0;
  logic [3:0]  ticks      = qdd_pkg::TicksReset;
  logic [15:0] step_size  = qdd_pkg::StepSizeReset;
  logic [1:0]  prev_ph [4] = '{default: qdd_pkg::PhasesReset};
  int          acc_q   [4] = '{default: 0};
  logic [31:0] pos_q   [4] = '{default: 32'd0};

  detent_result_t detent_reports_q [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int rx_hold = 0;
  bit no_idle = 1'b0;
  bit cw_dir [4] = '{default: 1'b1};

  task automatic decode_transition(input qdd_pkg::command_e cmd, input logic [1:0] ch,
                                   input logic [1:0] ph, output detent_result_t r);
    int          move;
    int          acc_next;
    logic [16:0] mag;
    r = '{chan: ch, step: qdd_pkg::EV_NONE, delta: '0, pos: '0};
    if (ch < EncoderCount) begin
      mag = mode_mask[ch] ? {1'b0, step_size} : 17'd1;
      if (cmd == qdd_pkg::CMD_PRIME) begin
        prev_ph[ch] = ph;
        acc_q[ch]   = 0;
        pos_q[ch]   = 32'd0;
      end else begin
        move = MoveTable[{prev_ph[ch], ph}];
        if (move != 0) begin
          acc_next = acc_q[ch] + move;
          if (acc_next >= int'(ticks)) begin
            acc_next  = 0;
            pos_q[ch] = pos_q[ch] + 32'd1;
            r.step    = qdd_pkg::EV_CW;
            r.delta   = mag;
          end else if (acc_next <= -int'(ticks)) begin
            acc_next  = 0;
            pos_q[ch] = pos_q[ch] - 32'd1;
            r.step    = qdd_pkg::EV_CCW;
            r.delta   = 17'd0 - mag;
          end
          acc_q[ch] = acc_next;
        end
        prev_ph[ch] = ph;
      end
      r.pos = pos_q[ch];
    end
  endtask

  task automatic send_beat(input qdd_pkg::command_e cmd, input logic [1:0] ch,
                           input logic [1:0] ph, input bit typed, input detent_result_t want);
    int             gap;
    detent_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    encoder_index <= ch;
    phase_a       <= ph[1];
    phase_b       <= ph[0];
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    decode_transition(cmd, ch, ph, predicted);
    detent_reports_q.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (detent_reports_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      qdd_pkg::REG_MODE_MASK: mode_mask = value[3:0];
      qdd_pkg::REG_TICKS:     ticks     = value[3:0];
      qdd_pkg::REG_STEP_SIZE: step_size = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic stim_row_t beat_row(qdd_pkg::command_e cmd, logic [1:0] ch,
                                         logic [1:0] ph);
    stim_row_t r;
    r = '{kind: ROW_BEAT, cmd: cmd, ch: ch, ph: ph, reg_idx: '0, value: '0,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t typed_row(qdd_pkg::command_e cmd, logic [1:0] ch,
                                          logic [1:0] ph, detent_result_t want);
    stim_row_t r;
    r = beat_row(cmd, ch, ph);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [15:0] value);
    stim_row_t r;
    r = beat_row(qdd_pkg::CMD_SAMPLE, 2'd0, 2'd0);
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.value   = value;
    return r;
  endfunction

  always @(posedge clk_i) begin
    detent_result_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid && !out_stall) begin
      if (detent_reports_q.size() == 0) begin
        if (mismatch_count < MaxReports)
          $display("unexpected result beat: chan %0d step %0d delta %0d pos %0d",
                   channel, step_event, step_delta, detent_position);
        mismatch_count <= mismatch_count + 1;
      end else begin
        want = detent_reports_q.pop_front();
        if (channel !== want.chan || step_event !== want.step ||
            step_delta !== want.delta || detent_position !== want.pos) begin
          if (mismatch_count < MaxReports)
            $display({"mismatch: expected chan %0d step %0d delta %0d pos %0d, ",
                      "got chan %0d step %0d delta %0d pos %0d"},
                     want.chan, want.step, want.delta, want.pos,
                     channel, step_event, step_delta, detent_position);
          mismatch_count <= mismatch_count + 1;
        end
      end
      rx_hold = no_idle ? 0 : $urandom_range(0, MaxIdle);
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
    end
    out_stall <= (rx_hold > 0);
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("quadrature_detent_decoder_core verification failed");
    $finish;
  end

  initial begin
    stim_row_t         rows [$];
    logic [1:0]        ch;
    logic [1:0]        ph;
    int                roll;
    qdd_pkg::command_e cmd;

    rows.push_back(typed_row(qdd_pkg::CMD_SAMPLE, 2'd0, 2'b11,
                             '{2'd0, qdd_pkg::EV_NONE, 17'sd0, 32'sd0}));
    rows.push_back(typed_row(qdd_pkg::CMD_PRIME,  2'd1, 2'b00,
                             '{2'd1, qdd_pkg::EV_NONE, 17'sd0, 32'sd0}));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd0, 2'b01));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd0, 2'b00));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd0, 2'b10));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd0, 2'b11));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd0, 2'b00));
    rows.push_back(cfg_row(qdd_pkg::REG_MODE_MASK, 16'hFFFF));
    rows.push_back(cfg_row(qdd_pkg::REG_STEP_SIZE, 16'hFFFF));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd1, 2'b01));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd1, 2'b11));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd1, 2'b10));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd1, 2'b00));
    rows.push_back(cfg_row(qdd_pkg::REG_TICKS, 16'd0));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd2, 2'b01));
    rows.push_back(cfg_row(qdd_pkg::REG_STEP_SIZE, 16'd0));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd2, 2'b00));
    rows.push_back(cfg_row(qdd_pkg::REG_TICKS, 16'd8));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd3, 2'b01));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd3, 2'b00));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd3, 2'b10));
    rows.push_back(cfg_row(qdd_pkg::REG_TICKS, 16'd1));
    rows.push_back(beat_row(qdd_pkg::CMD_SAMPLE, 2'd3, 2'b00));
    rows.push_back(typed_row(qdd_pkg::CMD_PRIME,  2'd0, 2'b10,
                             '{2'd0, qdd_pkg::EV_NONE, 17'sd0, 32'sd0}));
    rows.push_back(cfg_row(RegUnused, 16'hFFFF));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(rows[i].reg_idx, rows[i].value);
      end else begin
        send_beat(rows[i].cmd, rows[i].ch, rows[i].ph, rows[i].typed, rows[i].want);
      end
    end

    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_idle();
      no_idle = (phase == 2) || (phase == 6);
      write_reg(qdd_pkg::REG_TICKS,
                (phase < 6) ? {12'd0, TicksPlan[phase]} : 16'($urandom_range(1, 8)));
      write_reg(qdd_pkg::REG_STEP_SIZE,
                (phase < 6) ? SizePlan[phase] : 16'($urandom_range(1, 65535)));
      write_reg(qdd_pkg::REG_MODE_MASK, (phase == 0) ? 16'h0000 :
                                        (phase == 1) ? 16'h000F :
                                        16'($urandom_range(0, 15)));
      for (int n = 0; n < PhaseBeats; n++) begin
        ch   = 2'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        cmd  = qdd_pkg::CMD_SAMPLE;
        if (roll < 2) begin
          cmd = qdd_pkg::CMD_PRIME;
          ph  = 2'($urandom_range(0, 3));
        end else if (roll < 88) begin
          if ($urandom_range(0, 19) == 0) cw_dir[ch] = ~cw_dir[ch];
          ph = cw_dir[ch] ? CwNext[prev_ph[ch]] : CcwNext[prev_ph[ch]];
        end else begin
          ph = 2'($urandom_range(0, 3));
        end
        send_beat(cmd, ch, ph, 1'b0, '0);
      end
    end

    wait_idle();
    no_idle = 1'b0;
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && detent_reports_q.size() == 0) begin
      $display("quadrature_detent_decoder_core verification clean");
    end else begin
      $display("quadrature_detent_decoder_core verification failed");
    end
    $finish;
  end

endmodule
